// ----- rtl/core/signed_int_to_decimal_ascii_core_assert.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the signed integer to decimal text core
// each macro checks one property on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// same-cycle implication
`define SITDA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sitda same-cycle check failed");

// next-cycle implication
`define SITDA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sitda next-cycle check failed");

`endif

// ----- rtl/core/sitda_pkg.sv -----
// ---------------------------------------------------------------------------
// sitda_pkg
// widths, character codes and cell control type for the decimal text core
// ---------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // per-cycle command to every bcd cell
  typedef struct packed {
    logic clear;   // load zero
    logic dabble;  // add-3 adjust then shift in one bit
    logic rotate;  // take the digit of the lower neighbor
  } cell_ctl_t;

endpackage

// ----- rtl/core/sitda_bcd_cell.sv -----
// ---------------------------------------------------------------------------
// sitda_bcd_cell
// one decimal digit of the double-dabble chain, also shifts digit-wise
// ---------------------------------------------------------------------------
module sitda_bcd_cell (
  input  logic                              clk_i,
  input  sitda_pkg::cell_ctl_t              ctl_i,
  input  logic                              bit_i,
  input  logic [sitda_pkg::DIGIT_W-1:0]     digit_i,
  output logic                              bit_o,
  output logic [sitda_pkg::DIGIT_W-1:0]     digit_o
);

  logic [sitda_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic [sitda_pkg::DIGIT_W-1:0] adj;

  always_comb begin
    adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
    digit_d = digit_q;
    if (ctl_i.clear) begin
      digit_d = '0;
    end else if (ctl_i.dabble) begin
      digit_d = {adj[sitda_pkg::DIGIT_W-2:0], bit_i};
    end else if (ctl_i.rotate) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign bit_o   = adj[sitda_pkg::DIGIT_W-1];
  assign digit_o = digit_q;

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii_core.sv -----
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// renders a signed 32-bit number as decimal ascii, one character per request
// ---------------------------------------------------------------------------
// input channel: value_i with in_valid_i / in_stall_o, one number per request
// output channel: character_o and last_o with out_valid_o / out_stall_i
// a negative number first gives '-', then the digits come msb first with
// no leading zeros; zero gives a single '0'; last_o marks the final character
// the most negative number is handled as an unsigned magnitude, no overflow
// conversion: one double-dabble step per input bit through a row
// of ten bcd cells
// emission: the cells shift one digit per cycle toward the top cell unless the
// sign is sent or a stalled receiver holds them; leading zeros are dropped at
// one per cycle
// the next number is taken in the cycle after the last character is loaded
// one number at a time: in_stall_o is high from the accepting edge until the
// last character has been loaded into the output register
// the output register lets the next number start while that character waits
// a stalled receiver freezes the output register and holds emission
// reset clears the control state and the output valid; digits are not reset
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sitda_pkg::CHAR_W-1:0]      character_o,
  output logic                              last_o
);

  // controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic [sitda_pkg::CNT_W-1:0]         cnt_q, cnt_d;      // bits shifted so far
  logic [sitda_pkg::REM_W-1:0]         rem_q, rem_d;      // digits still in the row
  logic                                neg_q, neg_d;      // sign still to send
  logic                                started_q, started_d;
  logic [sitda_pkg::VALUE_W-1:0]       mag_q, mag_d;      // magnitude, msb shifts out
  logic                                out_valid_q, out_valid_d;
  logic [sitda_pkg::CHAR_W-1:0]        out_char_q, out_char_d;
  logic                                out_last_q, out_last_d;

  sitda_pkg::cell_ctl_t                ctl;
  logic [sitda_pkg::DIGIT_W-1:0]       digit_w [sitda_pkg::NUM_DIGITS];
  logic [sitda_pkg::NUM_DIGITS-1:0]    carry_w;
  logic [sitda_pkg::DIGIT_W-1:0]       top_digit;
  logic                                can_load;

  // row of bcd cells, cell 0 is the least significant digit
  for (genvar i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_low
      sitda_bcd_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .bit_i   (mag_q[sitda_pkg::VALUE_W-1]),
        .digit_i ('0),
        .bit_o   (carry_w[i]),
        .digit_o (digit_w[i])
      );
    end else begin : g_up
      sitda_bcd_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .bit_i   (carry_w[i-1]),
        .digit_i (digit_w[i-1]),
        .bit_o   (carry_w[i]),
        .digit_o (digit_w[i])
      );
    end
  end

  assign top_digit = digit_w[sitda_pkg::NUM_DIGITS-1];
  // output register free or being emptied this cycle
  assign can_load  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    started_d   = started_q;
    mag_d       = mag_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    ctl         = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // unsigned magnitude, covers the most negative number
          mag_d = value_i[sitda_pkg::VALUE_W-1] ?
                  (sitda_pkg::VALUE_W'(0) - $unsigned(value_i)) : $unsigned(value_i);
          neg_d     = value_i[sitda_pkg::VALUE_W-1];
          cnt_d     = '0;
          started_d = 1'b0;
          ctl.clear = 1'b1;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble = 1'b1;
        mag_d      = {mag_q[sitda_pkg::VALUE_W-2:0], 1'b0};
        cnt_d      = cnt_q + sitda_pkg::CNT_W'(1);
        if (cnt_q == sitda_pkg::CNT_W'(sitda_pkg::VALUE_W - 1)) begin
          rem_d   = sitda_pkg::REM_W'(sitda_pkg::NUM_DIGITS);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (neg_q) begin
          if (can_load) begin
            out_valid_d = 1'b1;
            out_char_d  = sitda_pkg::CHAR_MINUS;
            out_last_d  = 1'b0;
            neg_d       = 1'b0;
          end
        end else if (!started_q && (top_digit == '0) &&
                     (rem_q != sitda_pkg::REM_W'(1))) begin
          // drop a leading zero
          ctl.rotate = 1'b1;
          rem_d      = rem_q - sitda_pkg::REM_W'(1);
        end else if (can_load) begin
          out_valid_d = 1'b1;
          out_char_d  = sitda_pkg::CHAR_ZERO | sitda_pkg::CHAR_W'(top_digit);
          out_last_d  = (rem_q == sitda_pkg::REM_W'(1));
          ctl.rotate  = 1'b1;
          rem_d       = rem_q - sitda_pkg::REM_W'(1);
          started_d   = 1'b1;
          if (rem_q == sitda_pkg::REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      neg_q       <= neg_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = out_char_q;
  assign last_o      = out_last_q;

`include "signed_int_to_decimal_ascii_core_assert.svh"

  // an accepted number starts conversion
  `SITDA_ASSERT_NXT(a_accept_conv, in_valid_i && !in_stall_o, state_q == ST_CONV)
  // conversion ends after exactly one step per input bit
  `SITDA_ASSERT_NXT(a_conv_done,
    state_q == ST_CONV && cnt_q == sitda_pkg::CNT_W'(sitda_pkg::VALUE_W - 1),
    state_q == ST_EMIT)
  // emission always has a digit left to send
  `SITDA_ASSERT_IMP(a_emit_rem, state_q == ST_EMIT, rem_q != '0)
  // the sign is never the final character
  `SITDA_ASSERT_IMP(a_minus_not_last,
    out_valid_o && character_o == sitda_pkg::CHAR_MINUS, !last_o)
  // ten digits always hold the magnitude, nothing carries out of the top cell
  `SITDA_ASSERT_IMP(a_no_digit_overflow, state_q == ST_CONV,
    !carry_w[sitda_pkg::NUM_DIGITS-1])

endmodule
